// ----- hdl/udq_pkg.sv -----
// Package for the URL query pair decoder: item and state types, byte constants, hex helpers.
`default_nettype none
package udq_pkg;

  localparam int MaxItems = 4;
  localparam int CntW     = 3;

  localparam logic [7:0] ChPct   = 8'h25;  // '%'
  localparam logic [7:0] ChPlus  = 8'h2B;  // '+'
  localparam logic [7:0] ChAmp   = 8'h26;  // '&'
  localparam logic [7:0] ChEq    = 8'h3D;  // '='
  localparam logic [7:0] ChSpace = 8'h20;  // ' '

  localparam logic [1:0] EscNone  = 2'd0;
  localparam logic [1:0] EscPct   = 2'd1;
  localparam logic [1:0] EscDigit = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       in_value;
    logic       pair_done;
    logic       query_done;
    logic       run_end;
  } item_t;

  typedef struct packed {
    logic       value_phase;
    logic [1:0] escape_stage;
    logic [7:0] held_digit;
    logic       segment_open;
  } dec_state_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else v = 8'h00;
    hex_nib = v[3:0];
  endfunction

  function automatic item_t mk_item(input logic [7:0] b, input logic pres,
                                    input logic inv, input logic pair);
    item_t it;
    it.data_byte    = b;
    it.byte_present = pres;
    it.in_value     = inv;
    it.pair_done    = pair;
    it.query_done   = 1'b0;
    it.run_end      = 1'b0;
    mk_item = it;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/url_query_pair_decoder.sv -----
// Latency: the first result of a byte is offered the cycle after the byte is accepted.
// Throughput: one result beat per cycle while out_ready is high; a byte giving k results (0..4)
// holds the input until its last result leaves, so bytes giving one result each flow at one
// byte per cycle. Bytes that give no result (start of an escape, '=' after a key) never hold it.
// Reset (rst_n low, synchronous) empties the result buffer and returns the parser to key state.
`default_nettype none
module url_query_pair_decoder
  import udq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_query_byte,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data_byte,
  output logic            out_byte_present,
  output logic            out_in_value,
  output logic            out_pair_done,
  output logic            out_query_done,
  output logic            out_run_end
);

  dec_state_t           state_r, state_nxt;
  item_t [MaxItems-1:0] dec_items;
  logic [CntW-1:0]      dec_count;
  logic                 accept;
  logic                 can_load;
  item_t                cur_item;

  udq_decode u_decode (
    .query_byte (in_query_byte),
    .is_last    (in_is_last),
    .cur        (state_r),
    .nxt        (state_nxt),
    .items      (dec_items),
    .count      (dec_count)
  );

  assign in_ready = can_load;
  assign accept   = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n)      state_r <= '0;
    else if (accept) state_r <= state_nxt;
  end

  udq_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .load_items (dec_items),
    .load_count (dec_count),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (cur_item)
  );

  assign out_data_byte    = cur_item.data_byte;
  assign out_byte_present = cur_item.byte_present;
  assign out_in_value     = cur_item.in_value;
  assign out_pair_done    = cur_item.pair_done;
  assign out_query_done   = cur_item.query_done;
  assign out_run_end      = cur_item.run_end;

endmodule
`default_nettype wire

// ----- hdl/udq_decode.sv -----
// Combinational decode of one query byte into up to four result items and the next state.
`default_nettype none
module udq_decode
  import udq_pkg::*;
(
  input  wire logic [7:0]    query_byte,
  input  wire logic          is_last,
  input  wire dec_state_t    cur,
  output dec_state_t         nxt,
  output item_t [MaxItems-1:0] items,
  output logic [CntW-1:0]    count
);

  always_comb begin
    dec_state_t st;
    item_t [MaxItems-1:0] it;
    logic [CntW-1:0] n;
    logic [CntW-1:0] nm1;
    logic consumed;
    logic h_ok;

    st       = cur;
    it       = '0;
    n        = '0;
    consumed = 1'b0;
    h_ok     = is_hex(query_byte);

    // pending escape from earlier beats
    case (cur.escape_stage)
      EscPct: begin
        if (h_ok) begin
          st.held_digit   = query_byte;
          st.escape_stage = EscDigit;
          consumed        = 1'b1;
        end else begin
          it[n[1:0]] = mk_item(ChPct, 1'b1, st.value_phase, 1'b0);
          n = n + 1'b1;
          st.escape_stage = EscNone;
          st.held_digit   = '0;
        end
      end
      EscDigit: begin
        if (h_ok) begin
          it[n[1:0]] = mk_item({hex_nib(cur.held_digit), hex_nib(query_byte)},
                               1'b1, st.value_phase, 1'b0);
          n = n + 1'b1;
          consumed = 1'b1;
        end else begin
          it[n[1:0]] = mk_item(ChPct, 1'b1, st.value_phase, 1'b0);
          n = n + 1'b1;
          it[n[1:0]] = mk_item(cur.held_digit, 1'b1, st.value_phase, 1'b0);
          n = n + 1'b1;
        end
        st.escape_stage = EscNone;
        st.held_digit   = '0;
      end
      default: st.escape_stage = EscNone;
    endcase

    if (!consumed) begin
      if (query_byte == ChAmp) begin
        if (st.segment_open) begin
          it[n[1:0]] = mk_item(8'h00, 1'b0, 1'b0, 1'b1);
          n = n + 1'b1;
        end
        st.value_phase  = 1'b0;
        st.segment_open = 1'b0;
      end else if (query_byte == ChEq && !st.value_phase) begin
        st.value_phase  = 1'b1;
        st.segment_open = 1'b1;
      end else begin
        st.segment_open = 1'b1;
        if (query_byte == ChPct) begin
          st.escape_stage = EscPct;
          st.held_digit   = '0;
        end else begin
          it[n[1:0]] = mk_item((query_byte == ChPlus) ? ChSpace : query_byte,
                               1'b1, st.value_phase, 1'b0);
          n = n + 1'b1;
        end
      end
    end

    if (is_last) begin
      // cut-off escape goes out literally, then the open pair is closed
      if (st.escape_stage == EscPct || st.escape_stage == EscDigit) begin
        it[n[1:0]] = mk_item(ChPct, 1'b1, st.value_phase, 1'b0);
        n = n + 1'b1;
      end
      if (st.escape_stage == EscDigit) begin
        it[n[1:0]] = mk_item(st.held_digit, 1'b1, st.value_phase, 1'b0);
        n = n + 1'b1;
      end
      if (st.segment_open) begin
        it[n[1:0]] = mk_item(8'h00, 1'b0, 1'b0, 1'b1);
        n = n + 1'b1;
      end
      if (n == '0) begin
        it[n[1:0]] = mk_item(8'h00, 1'b0, 1'b0, 1'b0);
        n = n + 1'b1;
      end
      nm1 = n - 1'b1;
      it[nm1[1:0]].query_done = 1'b1;
      st = '0;
    end

    nm1 = n - 1'b1;
    if (n != '0) it[nm1[1:0]].run_end = 1'b1;

    nxt   = st;
    items = it;
    count = n;
  end

endmodule
`default_nettype wire

// ----- hdl/udq_outbuf.sv -----
// Result buffer: holds the items of one byte and hands them out one beat per cycle while out_ready is high.
`default_nettype none
module udq_outbuf
  import udq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire item_t [MaxItems-1:0] load_items,
  input  wire logic [CntW-1:0]      load_count,
  output logic                      can_load,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output item_t                     out_item
);

  item_t [MaxItems-1:0] items_r, items_nxt;
  logic [CntW-1:0]      rem_r, rem_nxt;
  logic                 pop;

  assign out_valid = (rem_r != '0);
  assign pop       = out_valid && out_ready;
  // free now, or the last held beat leaves this cycle
  assign can_load  = (rem_r == '0) || ((rem_r == CntW'(1)) && out_ready);
  assign out_item  = items_r[0];

  always_comb begin
    items_nxt = items_r;
    rem_nxt   = rem_r;
    if (load) begin
      items_nxt = load_items;
      rem_nxt   = load_count;
    end else if (pop) begin
      for (int i = 0; i < MaxItems - 1; i++) items_nxt[i] = items_r[i+1];
      rem_nxt = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    items_r <= items_nxt;
    if (!rst_n) rem_r <= '0;
    else        rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire
